// File: rtl/core/sorted_unique_set_table_defines.svh
// Assertion macros used by the checker file of the sorted set table.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SORTED_UNIQUE_SET_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_SET_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUST_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted set table check failed");

// The consequent must hold in the cycle after the antecedent.
`define SUST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted set table check failed");

`endif

// File: rtl/core/sust_pkg.sv
`timescale 1ns / 1ps
package sust_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int TYPE_W          = 2;
	localparam int KEY_W           = 32;
	localparam int COUNT_OUT_W     = 5;

	typedef enum logic [TYPE_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_LOOKUP = 2'd2
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_INSERT,
		ST_REMOVE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                   success;
		logic                   table_full;
		logic [COUNT_OUT_W-1:0] element_count;
	} rsp_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

endpackage

// File: rtl/core/sust_if.sv
`timescale 1ns / 1ps
interface sust_req_if import sust_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [TYPE_W-1:0]       req_type;
	logic signed [KEY_W-1:0] key_value;

	modport source (output valid, req_type, key_value, input ready);
	modport sink (input valid, req_type, key_value, output ready);
endinterface

interface sust_rsp_if import sust_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   success;
	logic                   table_full;
	logic [COUNT_OUT_W-1:0] element_count;

	modport source (output valid, success, table_full, element_count, input ready);
	modport sink (input valid, success, table_full, element_count, output ready);
endinterface

// File: rtl/core/sorted_unique_set_table.sv
`timescale 1ns / 1ps
// Sorted set of distinct signed values, kept in ascending order in a RAM.
// The req channel carries one request per transaction: req_type selects insert,
// remove or lookup and key_value is the value. The rsp channel returns exactly
// one transaction per request with success, table_full and the element count
// after the request. Unused request codes leave the table alone and fail.
// A request first scans the stored entries with one RAM read and one compare
// per cycle, then an insert or remove moves the entries above the hit position
// by one place, one move per cycle, through the same RAM port pair.
// Only one request is in flight: req.ready is high only while the sequencer is
// idle. The result sits in an output register, so a new request can be accepted
// while the previous result is still held. If the receiver stalls and a second
// result is ready, the sequencer waits until the register frees up.
// Reset empties the table at once; the RAM itself is not cleared, as entries at
// or above the count are never read.
module sorted_unique_set_table import sust_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sust_req_if.sink   req,
	sust_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic                   res_valid, res_ready;
	rsp_t                   res;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
	logic [VALUE_WIDTH-1:0] cmp_a, cmp_b;
	cmp_t                   cmp;
	logic                   out_valid_q;
	rsp_t                   out_q;

	sust_ctrl #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_type   (req.req_type),
		.in_key    (req.key_value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp       (cmp)
	);

	sust_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sust_cmp #(
		.WIDTH (VALUE_WIDTH)
	) u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.success       = out_q.success;
	assign rsp.table_full    = out_q.table_full;
	assign rsp.element_count = out_q.element_count;

endmodule

// File: rtl/core/sust_mem.sv
`timescale 1ns / 1ps
module sust_mem import sust_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int WIDTH = VALUE_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/sust_cmp.sv
`timescale 1ns / 1ps
module sust_cmp import sust_pkg::*; #(
	parameter int WIDTH = VALUE_WIDTH_DEF
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output cmp_t             res
);

	// Stored values are ordered as two's complement numbers.
	assign res.lt = $signed(a) < $signed(b);
	assign res.eq = (a == b);

endmodule

// File: rtl/core/sust_ctrl.sv
`timescale 1ns / 1ps
module sust_ctrl import sust_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TYPE_W-1:0]      in_type,
	input  logic [KEY_W-1:0]       in_key,
	output logic                   res_valid,
	input  logic                   res_ready,
	output rsp_t                   res,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [VALUE_WIDTH-1:0] mem_wdata,
	output logic [AW-1:0]          mem_raddr,
	input  logic [VALUE_WIDTH-1:0] mem_rdata,
	output logic [VALUE_WIDTH-1:0] cmp_a,
	output logic [VALUE_WIDTH-1:0] cmp_b,
	input  cmp_t                   cmp
);

	state_t                 state_q, state_d;
	req_type_t              type_q, type_d;
	logic [VALUE_WIDTH-1:0] key_q, key_d;
	logic [CW-1:0]          count_q, count_d;
	logic [CW-1:0]          idx_q, idx_d;
	logic [CW-1:0]          pos_q, pos_d;
	logic                   found_q, found_d;
	logic                   pend_q, pend_d;
	logic                   success_q, success_d;
	logic                   full_q, full_d;

	logic [63:0]            key_ext;
	logic [CW-1:0]          idx_m1, idx_m2;
	logic [CW:0]            idx_p1, idx_p2, cnt_x;

	assign key_ext = {32'h0, in_key};
	assign idx_m1  = idx_q - CW'(1);
	assign idx_m2  = idx_q - CW'(2);
	assign idx_p1  = {1'b0, idx_q} + (CW+1)'(1);
	assign idx_p2  = {1'b0, idx_q} + (CW+1)'(2);
	assign cnt_x   = {1'b0, count_q};

	assign cmp_a = mem_rdata;
	assign cmp_b = key_q;

	assign res.success       = success_q;
	assign res.table_full    = full_q;
	assign res.element_count = COUNT_OUT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		type_q    <= type_d;
		key_q     <= key_d;
		idx_q     <= idx_d;
		pos_q     <= pos_d;
		found_q   <= found_d;
		success_q <= success_d;
		full_q    <= full_d;
	end

	always_comb begin
		state_d   = state_q;
		type_d    = type_q;
		key_d     = key_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		found_d   = found_q;
		pend_d    = pend_q;
		success_d = success_q;
		full_d    = full_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;
		mem_raddr = '0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					type_d  = req_type_t'(in_type);
					key_d   = key_ext[VALUE_WIDTH-1:0];
					idx_d   = '0;
					pend_d  = 1'b0;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				// One read per cycle; the data of the previous read is compared now.
				if (idx_q != count_q) begin
					mem_raddr = idx_q[AW-1:0];
				end
				if (pend_q && !cmp.lt) begin
					pos_d   = idx_m1;
					found_d = cmp.eq;
					pend_d  = 1'b0;
					state_d = ST_DECIDE;
				end else if (idx_q == count_q) begin
					pos_d   = idx_q;
					found_d = 1'b0;
					pend_d  = 1'b0;
					state_d = ST_DECIDE;
				end else begin
					idx_d  = idx_p1[CW-1:0];
					pend_d = 1'b1;
				end
			end
			ST_DECIDE: begin
				success_d = 1'b0;
				full_d    = 1'b0;
				state_d   = ST_DONE;
				case (type_q)
					REQ_INSERT: begin
						if (!found_q) begin
							if (count_q == CW'(CAPACITY)) begin
								full_d = 1'b1;
							end else begin
								idx_d   = count_q;
								pend_d  = 1'b0;
								state_d = ST_INSERT;
							end
						end
					end
					REQ_REMOVE: begin
						if (found_q) begin
							idx_d   = pos_q;
							pend_d  = 1'b0;
							state_d = ST_REMOVE;
						end
					end
					REQ_LOOKUP: begin
						success_d = found_q;
					end
					default: begin
						success_d = 1'b0;
					end
				endcase
			end
			ST_INSERT: begin
				// Moves entries up by one from the top, one move per cycle once primed.
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q[AW-1:0];
					mem_wdata = mem_rdata;
					idx_d     = idx_m1;
					if (idx_m1 > pos_q) begin
						mem_raddr = idx_m2[AW-1:0];
						pend_d    = 1'b1;
					end else begin
						pend_d = 1'b0;
					end
				end else if (idx_q > pos_q) begin
					mem_raddr = idx_m1[AW-1:0];
					pend_d    = 1'b1;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = key_q;
					count_d   = count_q + CW'(1);
					success_d = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_REMOVE: begin
				// Moves entries above the removed one down by one.
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q[AW-1:0];
					mem_wdata = mem_rdata;
					idx_d     = idx_p1[CW-1:0];
					if (idx_p2 < cnt_x) begin
						mem_raddr = idx_p2[AW-1:0];
						pend_d    = 1'b1;
					end else begin
						pend_d = 1'b0;
					end
				end else if (idx_p1 < cnt_x) begin
					mem_raddr = idx_p1[AW-1:0];
					pend_d    = 1'b1;
				end else begin
					count_d   = count_q - CW'(1);
					success_d = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/sust_chk.sv
`timescale 1ns / 1ps
`include "sorted_unique_set_table_defines.svh"
module sust_chk import sust_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic                   success,
	input logic                   table_full,
	input logic [COUNT_OUT_W-1:0] element_count
);

	// A stalled result must not change under the receiver.
	`SUST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({success, table_full, element_count}))

	// A refused insert never reports success.
	`SUST_ASSERT_IMPL(a_full_not_success, rsp_valid && table_full, !success)

	// Only one request is worked on at a time.
	`SUST_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

	// The reported count never exceeds the table size.
	`SUST_ASSERT_IMPL(a_count_bound, rsp_valid, (CAPACITY > 31) || (element_count <= COUNT_OUT_W'(CAPACITY)))

endmodule

bind sorted_unique_set_table sust_chk #(
	.CAPACITY (CAPACITY)
) u_sust_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.success       (rsp.success),
	.table_full    (rsp.table_full),
	.element_count (rsp.element_count)
);
